// ===== rtl/core/ff55_pkg.sv =====
// shared constants and result type for the ff55 serial frame receiver
package ff55_pkg;

    localparam int FRAME_LIMIT = 64;
    localparam int POS_W       = $clog2(FRAME_LIMIT);

    localparam logic [7:0] HDR_FIRST  = 8'hFF;
    localparam logic [7:0] HDR_SECOND = 8'h55;

    localparam logic [POS_W-1:0] LEN_POS      = POS_W'(2);
    localparam logic [POS_W-1:0] HDR_POS      = POS_W'(1);
    localparam logic [POS_W:0]   DONE_MIN_POS = (POS_W+1)'(3);
    localparam logic [POS_W:0]   LIMIT_LAST   = (POS_W+1)'(FRAME_LIMIT - 1);

    typedef struct packed {
        logic       stored;
        logic [7:0] data_byte;
        logic [5:0] position;
        logic       header_found;
        logic       frame_done;
        logic       overflow_abort;
    } result_t;

endpackage

// ===== rtl/core/ff55_deframe.sv =====
// deframer state and per-byte next-state and result logic
module ff55_deframe (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  logic [7:0]            rx_byte,
    output ff55_pkg::result_t     result
);

    logic                        in_frame_reg, in_frame_next;
    logic [7:0]                  prev_byte_reg, prev_byte_next;
    logic [ff55_pkg::POS_W-1:0]  write_pos_reg, write_pos_next;
    logic [7:0]                  bytes_left_reg, bytes_left_next;
    logic [ff55_pkg::POS_W-1:0]  pos_base;
    logic [ff55_pkg::POS_W:0]    pos_inc;

    always_comb begin
        in_frame_next   = in_frame_reg;
        prev_byte_next  = prev_byte_reg;
        bytes_left_next = bytes_left_reg;
        pos_base        = write_pos_reg;
        result          = '0;
        result.data_byte = rx_byte;

        if (rx_byte == ff55_pkg::HDR_SECOND && !in_frame_reg) begin
            if (prev_byte_reg == ff55_pkg::HDR_FIRST) begin
                pos_base            = ff55_pkg::HDR_POS;
                in_frame_next       = 1'b1;
                result.header_found = 1'b1;
            end
        end else begin
            prev_byte_next = rx_byte;
            if (in_frame_reg) begin
                if (write_pos_reg == ff55_pkg::LEN_POS) begin
                    bytes_left_next = rx_byte;
                end else if (write_pos_reg > ff55_pkg::LEN_POS) begin
                    bytes_left_next = bytes_left_reg - 8'd1;
                end
                result.stored   = 1'b1;
                result.position = 6'(write_pos_reg);
            end
        end

        pos_inc = {1'b0, pos_base} + (ff55_pkg::POS_W+1)'(1);

        if (pos_inc > ff55_pkg::LIMIT_LAST) begin
            result.overflow_abort = in_frame_next;
            in_frame_next         = 1'b0;
            write_pos_next        = '0;
        end else begin
            write_pos_next = pos_inc[ff55_pkg::POS_W-1:0];
        end

        if (in_frame_next && bytes_left_next == 8'd0 && pos_inc > ff55_pkg::DONE_MIN_POS) begin
            in_frame_next     = 1'b0;
            result.frame_done = 1'b1;
            write_pos_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg   <= 1'b0;
            prev_byte_reg  <= 8'd0;
            write_pos_reg  <= '0;
            bytes_left_reg <= 8'd0;
        end else if (step) begin
            in_frame_reg   <= in_frame_next;
            prev_byte_reg  <= prev_byte_next;
            write_pos_reg  <= write_pos_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

endmodule

// ===== rtl/core/ff55_serial_frame_receiver_unit.sv =====
// top level of the ff55 serial frame receiver
//
// s_ channel: one received serial byte per transfer (s_rx_byte).
// m_ channel: one result per input byte: the byte itself, whether it was
//   stored as a frame byte and at which buffer position, and the flags
//   header_found, frame_done and overflow_abort.
// a frame opens with 0xFF 0x55; the byte at position 2 is the length and
//   each later byte counts it down until the frame is done.
// a taken byte is held in the input register; its result is then held in the
//   result register, which drives the m_ ports.
// throughput: one byte per cycle while m_ready is high; the state update for a
//   byte is compares, an increment and a decrement between the two registers.
// reset clears the frame state, the remembered previous byte and the valid
//   bits of both register stages; no transfer is pending afterwards.
// if the result is not taken, the result register holds, then the input
//   register holds its byte and s_ready drops; nothing is lost or repeated.
module ff55_serial_frame_receiver_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_stored,
    output logic [7:0] m_data_byte,
    output logic [5:0] m_position,
    output logic       m_header_found,
    output logic       m_frame_done,
    output logic       m_overflow_abort
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              out_valid_reg;
    ff55_pkg::result_t out_reg;
    ff55_pkg::result_t core_result;
    logic              advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    ff55_deframe u_deframe (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .result  (core_result)
    );

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    // result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= core_result;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_stored         = out_reg.stored;
    assign m_data_byte      = out_reg.data_byte;
    assign m_position       = out_reg.position;
    assign m_header_found   = out_reg.header_found;
    assign m_frame_done     = out_reg.frame_done;
    assign m_overflow_abort = out_reg.overflow_abort;

    a_done_excl_abort: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_frame_done && m_overflow_abort))
        else $error("frame_done and overflow_abort on one result");

    a_header_not_stored: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_header_found) |-> (!m_stored && !m_frame_done))
        else $error("header byte reported as stored or done");

    a_pos_zero_unstored: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_stored) |-> (m_position == 6'd0))
        else $error("position set on an unstored byte");

    a_stored_after_header: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_stored) |-> (m_position >= 6'd2))
        else $error("stored byte below the length position");

    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("input stage lost a byte while stalled");

endmodule
